// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the voxel scatter max pool RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/vsmp_pkg.sv =====
// Package for the voxel scatter max pool: widths, codes and item types.
// No dependencies; imported by the top level and by vsmp_axis.
`default_nettype none

package vsmp_pkg;

  // Field widths
  localparam int FEAT_W     = 16;
  localparam int COORD_W    = 20;
  localparam int SCALE_W    = 16;
  localparam int SIZE_W     = 5;
  localparam int PLANE_W    = 2;
  localparam int IDX_W      = 4;                  // log2 of the grid edge
  localparam int GRID       = 1 << IDX_W;
  localparam int ADDR_W     = PLANE_W + 3 * IDX_W;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Scaled coordinate: signed Q12.8 times unsigned Q8.8 gives Q.16
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = COORD_W + SCALE_W + 1;
  localparam int Q_W        = PROD_W - FRAC_W;

  // Value store word: touched flag on top of the feature
  localparam int VWORD_W    = FEAT_W + 1;

  // Reset values of the configuration registers
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(256);
  localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(16);

  typedef enum logic [MODE_W-1:0] {
    MODE_MAX   = 3'd0,
    MODE_READ  = 3'd1,
    MODE_BACK  = 3'd2,
    MODE_LOAD  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_X = 3'd0,
    CFG_SCALE_Y = 3'd1,
    CFG_SCALE_Z = 3'd2,
    CFG_SIZE_X  = 3'd3,
    CFG_SIZE_Y  = 3'd4,
    CFG_SIZE_Z  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [PLANE_W-1:0]        plane;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic signed [FEAT_W-1:0]  feature;
    logic [ADDR_W-1:0]         voxel_addr;
    logic signed [FEAT_W-1:0]  grad_in;
  } in_item_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] voxel_value;
    logic signed [FEAT_W-1:0] grad_out;
    logic                     in_range;
    logic                     hit;
  } out_item_t;

  // Per-axis result of the scale and range check
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } axis_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/voxel_scatter_max_pool_unit.sv =====
// Top level of the voxel scatter max pool. Depends on vsmp_pkg, vsmp_axis,
// vsmp_ram and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// Scatter max pooling of point features into a 4 x 16 x 16 x 16 voxel store.
// The scale multiply is registered at acceptance; the sequencer then steps
// through the index and range check, the store read, and the modify/write-back
// that also loads the output register, which waits while a held result is
// stalled. One item is in work at a time, set by the read-modify-write
// over the value store: a new item is taken only after the previous one is
// written back, and may be accepted while the previous result still waits.
// After reset the block sweeps all 16384 entries to clear the touched flags;
// no item is accepted during the sweep. Configuration writes are taken at any
// time but must only be issued while idle.
module voxel_scatter_max_pool_unit
  import vsmp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input items
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  // result items
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o
);

  // Sequencer codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_IDX   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;

  logic [2:0] state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  logic [SCALE_W-1:0] scale_x_q, scale_y_q, scale_z_q;
  logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;

  in_item_t          item_q;
  logic              ok_q, ok_d;
  logic [ADDR_W-1:0] addr_q, addr_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic      in_accept;
  logic      wb_go;
  axis_res_t res_x, res_y, res_z;

  logic               val_we, val_re;
  logic [ADDR_W-1:0]  val_waddr;
  logic [VWORD_W-1:0] val_wdata, val_rdata;
  logic               grad_we;
  logic [FEAT_W-1:0]  grad_rdata;

  logic                     wb_val_we, wb_grad_we;
  logic [VWORD_W-1:0]       wb_val_wdata;
  logic                     touched;
  logic signed [FEAT_W-1:0] stored;
  logic signed [FEAT_W-1:0] new_val;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign wb_go      = (state_q == ST_WB) && (!out_valid_q || !out_stall_i);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= SCALE_RST;
      scale_y_q <= SCALE_RST;
      scale_z_q <= SCALE_RST;
      size_x_q  <= SIZE_RST;
      size_y_q  <= SIZE_RST;
      size_z_q  <= SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE_X: scale_x_q <= cfg_wdata_i[SCALE_W-1:0];
        CFG_SCALE_Y: scale_y_q <= cfg_wdata_i[SCALE_W-1:0];
        CFG_SCALE_Z: scale_z_q <= cfg_wdata_i[SCALE_W-1:0];
        CFG_SIZE_X:  size_x_q  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SIZE_Y:  size_y_q  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SIZE_Z:  size_z_q  <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-axis scale and range check, product registered at acceptance
  vsmp_axis u_axis_x (
    .clk_i    (clk_i),
    .mul_en_i (in_accept),
    .coord_i  (in_item_i.coord_x),
    .scale_i  (scale_x_q),
    .size_i   (size_x_q),
    .res_o    (res_x)
  );

  vsmp_axis u_axis_y (
    .clk_i    (clk_i),
    .mul_en_i (in_accept),
    .coord_i  (in_item_i.coord_y),
    .scale_i  (scale_y_q),
    .size_i   (size_y_q),
    .res_o    (res_y)
  );

  vsmp_axis u_axis_z (
    .clk_i    (clk_i),
    .mul_en_i (in_accept),
    .coord_i  (in_item_i.coord_z),
    .scale_i  (scale_z_q),
    .size_i   (size_z_q),
    .res_o    (res_z)
  );

  // Every plane code is a valid plane, so only the axes bound the range
  assign ok_d = res_x.ok && res_y.ok && res_z.ok;

  // Address mux: linear address for read, load and clear, grid indices otherwise
  always_comb begin
    case (item_q.mode) inside
      MODE_READ, MODE_LOAD, MODE_CLEAR: addr_d = item_q.voxel_addr;
      default: addr_d = {item_q.plane, res_x.idx, res_y.idx, res_z.idx};
    endcase
  end

  // Item payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item_i;
    end
    if (state_q == ST_IDX) begin
      ok_q   <= ok_d;
      addr_q <= addr_d;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (&clr_cnt_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_IDX;
        end
      end
      ST_IDX:  state_d = ST_RD;
      ST_RD:   state_d = ST_WB;
      ST_WB: begin
        if (wb_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Write-back: modify the stored word and form the result
  assign touched = val_rdata[FEAT_W];
  assign stored  = $signed(val_rdata[FEAT_W-1:0]);
  assign new_val = (!touched || (stored < item_q.feature)) ? item_q.feature : stored;

  always_comb begin
    out_item_d          = '0;
    out_item_d.in_range = ok_q;
    wb_val_we           = 1'b0;
    wb_val_wdata        = '0;
    wb_grad_we          = 1'b0;
    case (item_q.mode)
      MODE_MAX: begin
        if (ok_q) begin
          wb_val_we              = 1'b1;
          wb_val_wdata           = {1'b1, new_val};
          out_item_d.voxel_value = new_val;
        end
      end
      MODE_READ: begin
        if (touched) begin
          out_item_d.voxel_value = stored;
          out_item_d.hit         = 1'b1;
        end
      end
      MODE_BACK: begin
        if (ok_q && touched) begin
          out_item_d.voxel_value = stored;
          if (stored == item_q.feature) begin
            out_item_d.grad_out = $signed(grad_rdata);
            out_item_d.hit      = 1'b1;
          end
        end
      end
      MODE_LOAD: wb_grad_we = 1'b1;
      // Clear drops the touched flag; the value is rewritten on next touch
      MODE_CLEAR: wb_val_we = 1'b1;
      default: ;
    endcase
  end

  // Store ports: the clearing sweep owns the value store after reset
  assign val_re    = (state_q == ST_RD);
  assign val_we    = (state_q == ST_CLEAR) || (wb_go && wb_val_we);
  assign val_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : addr_q;
  assign val_wdata = (state_q == ST_CLEAR) ? '0 : wb_val_wdata;
  assign grad_we   = wb_go && wb_grad_we;

  vsmp_ram #(
    .WIDTH  (VWORD_W),
    .ADDR_W (ADDR_W)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (val_re),
    .raddr_i (addr_q),
    .rdata_o (val_rdata)
  );

  vsmp_ram #(
    .WIDTH  (FEAT_W),
    .ADDR_W (ADDR_W)
  ) u_grad_ram (
    .clk_i   (clk_i),
    .we_i    (grad_we),
    .waddr_i (addr_q),
    .wdata_i (item_q.grad_in),
    .re_i    (val_re),
    .raddr_i (addr_q),
    .rdata_o (grad_rdata)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (wb_go) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_go) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  `ASSERT_HOLDS(a_accept_starts_item, clk_i, rst_ni, in_accept |=> (state_q == ST_IDX))
  `ASSERT_HOLDS(a_result_from_wb, clk_i, rst_ni, (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_WB))
  `ASSERT_NEVER(a_write_outside_wb, clk_i, rst_ni, (val_we || grad_we) && (state_q != ST_CLEAR) && (state_q != ST_WB))
  `ASSERT_NEVER(a_grad_without_hit, clk_i, rst_ni, out_valid_o && (out_item_o.grad_out != '0) && !out_item_o.hit)

endmodule

`default_nettype wire

// ===== hw/rtl/vsmp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vsmp_ram #(
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 14
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vsmp_axis.sv =====
// One coordinate axis: registered scale multiply, truncation toward zero
// and range check against the configured size. Depends on vsmp_pkg.
`default_nettype none

module vsmp_axis
  import vsmp_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      mul_en_i,
  input  wire logic signed [COORD_W-1:0] coord_i,
  input  wire logic [SCALE_W-1:0]        scale_i,
  input  wire logic [SIZE_W-1:0]         size_i,
  output axis_res_t                      res_o
);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [PROD_W-1:0]        biased;
  logic [Q_W-1:0]           q;
  logic [SIZE_W-1:0]        lim;

  // Signed coordinate times unsigned scale
  assign prod_d = coord_i * $signed({1'b0, scale_i});

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // Round toward zero: add all-ones fraction to negative products
  assign biased = prod_q + {{(PROD_W - FRAC_W){1'b0}}, {FRAC_W{prod_q[PROD_W-1]}}};
  assign q      = biased[PROD_W-1:FRAC_W];

  // Usable cells are the smaller of size and grid edge
  assign lim = (size_i < SIZE_W'(GRID)) ? size_i : SIZE_W'(GRID);

  assign res_o.ok  = !q[Q_W-1] && (q < Q_W'(lim));
  assign res_o.idx = q[IDX_W-1:0];

endmodule

`default_nettype wire
